// ===== sv/tkst_pkg.sv =====
package tkst_pkg;

    // Table geometry.
    localparam int TABLE_SIZE = 10;
    localparam int IDX_W      = $clog2(TABLE_SIZE + 1);
    localparam int RANK_W     = 6;

    // Input operation codes.
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_IGNORED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_UPDATED  = 3'd2,
        STAT_TOO_LOW  = 3'd3,
        STAT_ROW      = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DELETE,
        ST_INSERT,
        ST_READ
    } t_state;

    // What every cell of the chain does in the current cycle.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_DELETE,
        CM_INSERT,
        CM_ROTATE
    } t_cell_mode;

    // One table entry as held by a cell.
    typedef struct packed {
        logic               used;
        logic [30:0]        id;
        logic signed [31:0] score;
        logic [63:0]        name;
    } t_entry;

    // Command broadcast from the controller to all cells.
    typedef struct packed {
        t_cell_mode         mode;
        logic [IDX_W-1:0]   idx;
        logic [30:0]        id;
        logic signed [31:0] score;
        logic [63:0]        name;
    } t_cell_cmd;

endpackage

// ===== sv/top_k_score_table_unit.sv =====
// Ranked score table of TABLE_SIZE entries held in a chain of cells.
// Input: an item transfers at a clock edge with start high and busy low.
// A check item (op 0) offers a score for a player; a read item (op 1)
// lists the table in rank order.
// Output: each result is on the o_ ports for one cycle with o_valid high;
// o_last marks the final result of an item. The receiver cannot stall.
// Sequence after the transfer edge: every item first spends an evaluation
// state. An ignored or too-low check registers its result out of that state;
// an insertion passes through the insert state, and an update first through a
// delete state that removes the old entry from the chain before re-inserting
// it. A read then rotates the chain once per cycle until it has turned fully,
// showing one row per cycle in rank order from the head cell; busy stays high
// through the evaluation state and the full turn. A read of an empty table
// does not rotate and shows a single row with o_row_valid low.
// Busy drops in the cycle the final result is shown, so the next item can
// transfer then, except after a read of a partly filled table, where busy
// stays high until the chain has turned fully.
// Reset clears the used flags and leaves the table empty.
module top_k_score_table_unit
    import tkst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [30:0]        i_player_id,
    input  logic signed [31:0] i_score,
    input  logic [63:0]        i_name_tag,
    input  logic               i_name_present,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [RANK_W-1:0]  o_rank,
    output logic               o_row_valid,
    output logic [30:0]        o_row_id,
    output logic signed [31:0] o_row_score,
    output logic [63:0]        o_row_name_tag,
    output logic               o_last
);

    t_entry                w_entries [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] w_before;
    logic [TABLE_SIZE-1:0] w_match;
    logic [TABLE_SIZE-1:0] w_used;
    t_cell_cmd             w_cmd;
    t_entry                w_row;

    // Chain of cells; each sees its neighbors above and below.
    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_before;

        if (k == 0) begin : g_head
            assign w_prev        = '0;
            assign w_prev_before = 1'b1;
        end else begin : g_body
            assign w_prev        = w_entries[k-1];
            assign w_prev_before = w_before[k-1];
        end

        if (k == TABLE_SIZE - 1) begin : g_tail
            assign w_next = (w_cmd.mode == CM_ROTATE) ? w_entries[0] : '0;
        end else begin : g_link
            assign w_next = w_entries[k+1];
        end

        tkst_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_pos         (IDX_W'(k)),
            .i_cmd         (w_cmd),
            .i_prev_before (w_prev_before),
            .i_prev        (w_prev),
            .i_next        (w_next),
            .o_entry       (w_entries[k]),
            .o_before      (w_before[k]),
            .o_match       (w_match[k])
        );

        assign w_used[k] = w_entries[k].used;
    end

    // Sequencing and result register.
    tkst_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_player_id    (i_player_id),
        .i_score        (i_score),
        .i_name_tag     (i_name_tag),
        .i_name_present (i_name_present),
        .i_entries      (w_entries),
        .i_match        (w_match),
        .o_cmd          (w_cmd),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_rank         (o_rank),
        .o_row          (w_row),
        .o_last         (o_last)
    );

    assign o_row_valid    = w_row.used;
    assign o_row_id       = w_row.id;
    assign o_row_score    = w_row.score;
    assign o_row_name_tag = w_row.name;

`ifndef SYNTHESIS
    // While idle, used slots form a packed prefix of the chain.
    a_used_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> ((w_used & (w_used + TABLE_SIZE'(1))) == '0))
        else $error("used slots are not packed");

    // A player id is held by at most one slot.
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("player id held by more than one slot");

    // A result only follows a cycle of work.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without work in progress");

    // The rows of a read come in consecutive cycles.
    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a multi-row result");

    // The final result of one item is never directly followed by another.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result directly after a final result");
`endif

endmodule

// ===== sv/tkst_cell.sv =====
module tkst_cell
    import tkst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_pos,
    input  t_cell_cmd        i_cmd,
    input  logic             i_prev_before,
    input  t_entry           i_prev,
    input  t_entry           i_next,
    output t_entry           o_entry,
    output logic             o_before,
    output logic             o_match
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_before;

    // An entry ranks ahead of the incoming one. Entries that sat above the
    // updated slot win ties; entries that sat below it lose them.
    always_comb begin
        if (i_pos < i_cmd.idx) begin
            w_before = r_entry.used && (r_entry.score >= i_cmd.score);
        end else begin
            w_before = r_entry.used && (r_entry.score > i_cmd.score);
        end
    end

    // Next content of the cell from its own entry and its neighbors.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.mode)
            CM_HOLD: begin
                n_entry = r_entry;
            end
            CM_DELETE: begin
                if (i_pos >= i_cmd.idx) begin
                    n_entry = i_next;
                end
            end
            CM_INSERT: begin
                if (w_before) begin
                    n_entry = r_entry;
                end else if (i_prev_before) begin
                    n_entry.used  = 1'b1;
                    n_entry.id    = i_cmd.id;
                    n_entry.score = i_cmd.score;
                    n_entry.name  = i_cmd.name;
                end else begin
                    n_entry = i_prev;
                end
            end
            CM_ROTATE: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Only the used flag is cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.used <= 1'b0;
        end else begin
            r_entry.used <= n_entry.used;
        end
        r_entry.id    <= n_entry.id;
        r_entry.score <= n_entry.score;
        r_entry.name  <= n_entry.name;
    end

    assign o_entry  = r_entry;
    assign o_before = w_before;
    assign o_match  = r_entry.used && (r_entry.id == i_cmd.id);

endmodule

// ===== sv/tkst_ctrl.sv =====
module tkst_ctrl
    import tkst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [30:0]        i_player_id,
    input  logic signed [31:0] i_score,
    input  logic [63:0]        i_name_tag,
    input  logic               i_name_present,
    input  t_entry             i_entries [TABLE_SIZE],
    input  logic [TABLE_SIZE-1:0] i_match,
    output t_cell_cmd          o_cmd,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [RANK_W-1:0]  o_rank,
    output t_entry             o_row,
    output logic               o_last
);

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_op;
    logic [30:0]        r_id;
    logic signed [31:0] r_score;
    logic [63:0]        r_name;
    logic               r_present;
    logic               r_valid;
    logic               n_valid;
    t_status            r_status;
    t_status            n_status;
    logic [RANK_W-1:0]  r_rank;
    logic [RANK_W-1:0]  n_rank;
    t_entry             r_row;
    t_entry             n_row;
    logic               r_last;
    logic               n_last;
    logic [IDX_W-1:0]   w_fidx;
    logic [63:0]        w_fname;
    logic signed [31:0] w_lowest;
    logic               w_found;
    logic               w_full;
    logic               w_next_used;

    // Slot and name of the matching id, and score of the last used slot.
    always_comb begin
        w_fidx   = '0;
        w_fname  = '0;
        w_lowest = '0;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            if (i_match[k]) begin
                w_fidx  = w_fidx | IDX_W'(k);
                w_fname = w_fname | i_entries[k].name;
            end
            if (i_entries[k].used &&
                ((k == TABLE_SIZE - 1) || !i_entries[(k + 1) % TABLE_SIZE].used)) begin
                w_lowest = w_lowest | i_entries[k].score;
            end
        end
    end

    assign w_found     = |i_match;
    assign w_full      = i_entries[TABLE_SIZE-1].used;
    assign w_next_used = (TABLE_SIZE > 1) ? i_entries[1 % TABLE_SIZE].used : 1'b0;

    // Next state, cell command and result.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_valid      = 1'b0;
        n_status     = STAT_IGNORED;
        n_rank       = '0;
        n_row        = '0;
        n_last       = 1'b1;
        o_cmd.mode   = CM_HOLD;
        o_cmd.idx    = r_idx;
        o_cmd.id     = r_id;
        o_cmd.score  = r_score;
        o_cmd.name   = r_name;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_op == OP_READ) begin
                    if (!i_entries[0].used) begin
                        n_valid  = 1'b1;
                        n_status = STAT_ROW;
                        n_state  = ST_IDLE;
                    end else begin
                        n_cnt   = '0;
                        n_state = ST_READ;
                    end
                end else if (!r_present) begin
                    n_valid  = 1'b1;
                    n_status = STAT_IGNORED;
                    n_state  = ST_IDLE;
                end else if (w_full && !(r_score > w_lowest)) begin
                    n_valid  = 1'b1;
                    n_status = STAT_TOO_LOW;
                    n_state  = ST_IDLE;
                end else if (w_found) begin
                    n_idx   = w_fidx;
                    n_state = ST_DELETE;
                end else begin
                    n_idx   = IDX_W'(TABLE_SIZE);
                    n_state = ST_INSERT;
                end
            end
            ST_DELETE: begin
                o_cmd.mode = CM_DELETE;
                n_state    = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.mode = CM_INSERT;
                n_valid    = 1'b1;
                n_status   = (r_idx == IDX_W'(TABLE_SIZE)) ? STAT_INSERTED : STAT_UPDATED;
                n_state    = ST_IDLE;
            end
            ST_READ: begin
                // Cell 0 holds the entry of rank r_cnt; the chain rotates once
                // per cycle and is back in place after a full turn.
                o_cmd.mode = CM_ROTATE;
                if (i_entries[0].used) begin
                    n_valid  = 1'b1;
                    n_status = STAT_ROW;
                    n_rank   = RANK_W'(r_cnt);
                    n_row    = i_entries[0];
                    n_last   = (r_cnt == IDX_W'(TABLE_SIZE - 1)) || !w_next_used;
                end
                n_cnt = r_cnt + IDX_W'(1);
                if (r_cnt == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Item capture on transfer, working counters and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_op      <= i_op;
            r_id      <= i_player_id;
            r_score   <= i_score;
            r_name    <= i_name_tag;
            r_present <= i_name_present;
        end else if (n_state == ST_DELETE) begin
            // An update keeps the name of the stored entry.
            r_name    <= w_fname;
        end
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        if (n_valid) begin
            r_status <= n_status;
            r_rank   <= n_rank;
            r_row    <= n_row;
            r_last   <= n_last;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_rank   = r_rank;
    assign o_row    = r_row;
    assign o_last   = r_last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tkst_pkg::*;

    localparam int RANDOM_ITEMS = 145;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = TABLE_SIZE + 12;

    // One input item, with an optional typed-in status for directed rows.
    typedef struct {
        logic               op;
        logic [30:0]        id;
        logic signed [31:0] score;
        logic [63:0]        name;
        logic               present;
        logic               typed;
        t_status            typed_status;
    } t_stim;

    // One result as it appears on the o_ ports.
    typedef struct {
        t_status            status;
        logic [RANK_W-1:0]  rank;
        logic               row_valid;
        logic [30:0]        id;
        logic signed [31:0] score;
        logic [63:0]        name;
        logic               last;
    } t_board_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [30:0]        i_player_id;
    logic signed [31:0] i_score;
    logic [63:0]        i_name_tag;
    logic               i_name_present;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [RANK_W-1:0]  o_rank;
    logic               o_row_valid;
    logic [30:0]        o_row_id;
    logic signed [31:0] o_row_score;
    logic [63:0]        o_row_name_tag;
    logic               o_last;

    // Side information driven along with each item.
    logic               drv_typed;
    t_status            drv_typed_status;

    // Leaderboard as the bench believes it to be; one spare slot for overflow.
    logic [30:0]        board_id    [TABLE_SIZE+1];
    logic signed [31:0] board_score [TABLE_SIZE+1];
    logic [63:0]        board_name  [TABLE_SIZE+1];
    int                 board_count;

    t_board_row rows_due[$];
    t_board_row fresh_rows[$];
    t_stim      stim_rows[$];
    int         mismatch_count;
    int         cycle_count;

    top_k_score_table_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_player_id    (i_player_id),
        .i_score        (i_score),
        .i_name_tag     (i_name_tag),
        .i_name_present (i_name_present),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_rank         (o_rank),
        .o_row_valid    (o_row_valid),
        .o_row_id       (o_row_id),
        .o_row_score    (o_row_score),
        .o_row_name_tag (o_row_name_tag),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append one result to the batch the current item produces.
    function automatic void emit_row(t_status status, int rank, logic valid, int slot,
                                     logic last);
        t_board_row r;
        r.status    = status;
        r.rank      = RANK_W'(rank);
        r.row_valid = valid;
        r.id        = valid ? board_id[slot] : '0;
        r.score     = valid ? board_score[slot] : '0;
        r.name      = valid ? board_name[slot] : '0;
        r.last      = last;
        fresh_rows.insert(fresh_rows.size(), r);
    endfunction

    // Stable descending insertion sort over the first n slots.
    function automatic void resort_board(int n);
        logic [30:0]        tid;
        logic signed [31:0] tsc;
        logic [63:0]        tnm;
        for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && board_score[j-1] < board_score[j]; j--) begin
                tid = board_id[j-1];
                tsc = board_score[j-1];
                tnm = board_name[j-1];
                board_id[j-1]    = board_id[j];
                board_score[j-1] = board_score[j];
                board_name[j-1]  = board_name[j];
                board_id[j]      = tid;
                board_score[j]   = tsc;
                board_name[j]    = tnm;
            end
        end
    endfunction

    // Apply one item to the leaderboard and collect the results it causes.
    function automatic void predict_leaderboard(logic op, logic [30:0] id,
                                                logic signed [31:0] score,
                                                logic [63:0] name, logic present);
        int hit;
        hit = -1;
        if (op == OP_READ) begin
            if (board_count == 0) begin
                emit_row(STAT_ROW, 0, 1'b0, 0, 1'b1);
            end else begin
                for (int i = 0; i < board_count; i++)
                    emit_row(STAT_ROW, i, 1'b1, i, i + 1 == board_count);
            end
        end else if (!present) begin
            emit_row(STAT_IGNORED, 0, 1'b0, 0, 1'b1);
        end else if (board_count < TABLE_SIZE || score > board_score[board_count-1]) begin
            for (int i = 0; i < board_count; i++)
                if (hit < 0 && board_id[i] == id) hit = i;
            if (hit >= 0) begin
                // An update changes the score only; the name stays.
                board_score[hit] = score;
                resort_board(board_count);
                emit_row(STAT_UPDATED, 0, 1'b0, 0, 1'b1);
            end else begin
                board_id[board_count]    = id;
                board_score[board_count] = score;
                board_name[board_count]  = name;
                resort_board(board_count + 1);
                if (board_count < TABLE_SIZE) board_count++;
                emit_row(STAT_INSERTED, 0, 1'b0, 0, 1'b1);
            end
        end else begin
            emit_row(STAT_TOO_LOW, 0, 1'b0, 0, 1'b1);
        end
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Result checking first, then the prediction for an item transferred at this edge.
    always @(posedge i_clk) begin
        t_board_row want;
        if (i_rst_n && o_valid) begin
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d id %0h",
                         $time, o_status, o_row_id);
                mismatch_count++;
            end else begin
                want = rows_due.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("rank", 64'(want.rank), 64'(o_rank));
                check_field("row_valid", 64'(want.row_valid), 64'(o_row_valid));
                check_field("row_id", 64'(want.id), 64'(o_row_id));
                check_field("row_score", 64'($unsigned(want.score)),
                            64'($unsigned(o_row_score)));
                check_field("row_name_tag", want.name, o_row_name_tag);
                check_field("last", 64'(want.last), 64'(o_last));
            end
        end
        if (i_rst_n && start && !busy) begin
            fresh_rows.delete();
            predict_leaderboard(i_op, i_player_id, i_score, i_name_tag, i_name_present);
            if (drv_typed) begin
                want.status    = drv_typed_status;
                want.rank      = '0;
                want.row_valid = 1'b0;
                want.id        = '0;
                want.score     = '0;
                want.name      = '0;
                want.last      = 1'b1;
                rows_due.insert(rows_due.size(), want);
            end else begin
                foreach (fresh_rows[k]) rows_due.insert(rows_due.size(), fresh_rows[k]);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic add_row(input logic op, input logic [30:0] id,
                           input logic signed [31:0] score, input logic [63:0] name,
                           input logic present, input logic typed, input t_status st);
        t_stim s;
        s.op           = op;
        s.id           = id;
        s.score        = score;
        s.name         = name;
        s.present      = present;
        s.typed        = typed;
        s.typed_status = st;
        stim_rows.insert(stim_rows.size(), s);
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one item and hold it until the transfer, then maybe idle.
    task automatic offer_item(input t_stim s, input logic no_gap);
        int gap;
        start            <= 1'b1;
        i_op             <= s.op;
        i_player_id      <= s.id;
        i_score          <= s.score;
        i_name_tag       <= s.name;
        i_name_present   <= s.present;
        drv_typed        <= s.typed;
        drv_typed_status <= s.typed_status;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every expected result has come.
    task automatic wait_board_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (rows_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_stim random_item();
        t_stim s;
        int    r;
        int    sc;
        s.typed        = 1'b0;
        s.typed_status = STAT_IGNORED;
        s.op           = ($urandom_range(0, 99) < 15) ? OP_READ : OP_CHECK;
        s.present      = ($urandom_range(0, 99) < 8) ? 1'b0 : 1'b1;
        s.name         = {$urandom, $urandom};
        // A small id pool makes updates common.
        if ($urandom_range(0, 99) < 75) s.id = 31'($urandom_range(0, 15));
        else s.id = 31'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            sc = $urandom_range(0, 100);
            s.score = 32'(sc - 50);
        end else if (r < 75) begin
            s.score = $urandom;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0: s.score = 32'sh7FFF_FFFF;
                1: s.score = 32'sh8000_0000;
                2: s.score = '0;
                default: s.score = '1;
            endcase
        end else begin
            s.score = 32'($urandom_range(1000, 100000));
        end
        return s;
    endfunction

    // Stimulus: directed table, then random items.
    initial begin
        start            <= 1'b0;
        i_op             <= OP_CHECK;
        i_player_id      <= '0;
        i_score          <= '0;
        i_name_tag       <= '0;
        i_name_present   <= 1'b0;
        drv_typed        <= 1'b0;
        drv_typed_status <= STAT_IGNORED;
        i_rst_n          <= 1'b0;
        board_count      = 0;
        mismatch_count   = 0;
        cycle_count      = 0;

        // Empty table reads, an empty name with all other bits set.
        add_row(OP_READ, 31'd0, 32'sd0, 64'd0, 1'b1, 1'b1, STAT_ROW);
        add_row(OP_CHECK, '1, '1, '1, 1'b0, 1'b1, STAT_IGNORED);
        add_row(OP_READ, '1, '1, '1, 1'b0, 1'b1, STAT_ROW);
        // Extreme fields, then an equal-score pair.
        add_row(OP_CHECK, 31'd0, 32'sh8000_0000, 64'd0, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, '1, 32'sh7FFF_FFFF, '1, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd5, 32'sd100, 64'hA5A5_0000_0000_0005, 1'b1, 1'b1,
                STAT_INSERTED);
        add_row(OP_CHECK, 31'd6, 32'sd100, 64'h5A5A_0000_0000_0006, 1'b1, 1'b1,
                STAT_INSERTED);
        add_row(OP_READ, 31'd0, 32'sd0, 64'd0, 1'b1, 1'b0, STAT_ROW);
        // Update to a lower score with a new name, then an update into a tie.
        add_row(OP_CHECK, 31'd5, 32'sd50, 64'hDEAD_BEEF_0000_0000, 1'b1, 1'b0, STAT_UPDATED);
        add_row(OP_CHECK, 31'd0, 32'sd100, 64'd1, 1'b1, 1'b0, STAT_UPDATED);
        // Fill the table.
        add_row(OP_CHECK, 31'd7, 32'sd10, 64'd7, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd8, 32'sd20, 64'd8, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd9, 32'sd30, 64'd9, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd10, 32'sd40, 64'd10, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd11, 32'sd60, 64'd11, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_CHECK, 31'd12, 32'sd70, 64'd12, 1'b1, 1'b1, STAT_INSERTED);
        add_row(OP_READ, 31'd0, 32'sd0, 64'd0, 1'b1, 1'b0, STAT_ROW);
        // Full table: equal to the lowest, and a known id below the lowest.
        add_row(OP_CHECK, 31'd13, 32'sd10, 64'd13, 1'b1, 1'b1, STAT_TOO_LOW);
        add_row(OP_CHECK, 31'd7, 32'sd5, 64'd7, 1'b1, 1'b1, STAT_TOO_LOW);
        add_row(OP_CHECK, 31'd7, 32'sd11, 64'd7, 1'b1, 1'b0, STAT_UPDATED);
        // Overflow drops the last-ranked entry.
        add_row(OP_CHECK, 31'd20, 32'sd1000, 64'd20, 1'b1, 1'b0, STAT_INSERTED);
        add_row(OP_CHECK, 31'd21, 32'sd12, 64'd21, 1'b0, 1'b1, STAT_IGNORED);
        add_row(OP_READ, 31'd0, 32'sd0, 64'd0, 1'b1, 1'b0, STAT_ROW);
        add_row(OP_CHECK, 31'd22, 32'sh8000_0000, 64'd22, 1'b1, 1'b1, STAT_TOO_LOW);
        add_row(OP_READ, '1, '1, '1, 1'b0, 1'b0, STAT_ROW);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) offer_item(stim_rows[k], 1'b0);

        // Random items; every fourth block of twenty runs without gaps.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) wait_board_drained();
            offer_item(random_item(), (k / 20) % 4 == 2);
        end

        wait_board_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
